@@ src/tcpg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tcpg_pkg;

  // port widths
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned PACK_ID_W = 5;
  localparam int unsigned FRAMES_W  = 7;
  localparam int unsigned SECONDS_W = 7;
  localparam int unsigned MINUTES_W = 7;
  localparam int unsigned HOURS_W   = 6;

  // pack constants
  localparam logic [PACK_ID_W-1:0] TC_PACK_ID = 5'h13;
  localparam logic [FRAMES_W-1:0]  DROP_FLAG  = 7'h40;

  // drop-frame divisors, halved since the doubled count is always even
  localparam int unsigned FRAMES_PER_MIN_DROP     = 60 * 30 - 2;
  localparam int unsigned FRAMES_PER_TEN_MIN_DROP = 10 * 60 * 30 - 18;
  localparam int unsigned HALF_MIN_DROP           = FRAMES_PER_MIN_DROP / 2;
  localparam int unsigned HALF_TEN_MIN_DROP       = FRAMES_PER_TEN_MIN_DROP / 2;

  localparam int unsigned RATE_PAL      = 25;
  localparam int unsigned RATE_NTSC     = 30;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned HOURS_PER_DAY = 24;

  // two-digit bcd for values below 64; v*13>>7 equals v/10 there
  function automatic logic [6:0] bcd2(input logic [5:0] v);
    logic [9:0] prod;
    logic [2:0] tens;
    logic [5:0] diff;
    prod = 10'(v) * 10'd13;
    tens = prod[9:7];
    diff = v - 6'(6'(tens) * 6'd10);
    return {tens, diff[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ src/dv_timecode_pack_generator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// dv timecode pack generator: turns a running frame count into the five-byte
// dv subcode timecode pack (id 0x13, then bcd frames, seconds, minutes and
// hours mod 24). with in_is_fifty_hz low the count is first converted to a
// 30 fps drop-frame count, n + 2n/1798 - 2(n+2)/17982 in wrapping 32-bit math.
// a request is taken whenever start is high; busy is always low, so a new
// request may enter every cycle. each request gives exactly one result,
// shown on the out_ ports for a single cycle with out_valid high, after the
// request has passed through every pipeline stage. the receiver cannot hold
// results off and none is needed: the pipeline never stalls. the stages are
// an input register, the two drop-frame dividers side by side (two stages),
// the register holding the adjusted count, four chained constant dividers
// of two stages each (frame rate, seconds, minutes, hours) and the output
// register.
module dv_timecode_pack_generator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [tcpg_pkg::COUNT_W-1:0]      in_frame_count,
  input  wire logic                              in_is_fifty_hz,
  output logic                                   out_valid,
  output logic      [tcpg_pkg::PACK_ID_W-1:0]    out_pack_id,
  output logic      [tcpg_pkg::FRAMES_W-1:0]     out_frames_byte,
  output logic      [tcpg_pkg::SECONDS_W-1:0]    out_seconds_byte,
  output logic      [tcpg_pkg::MINUTES_W-1:0]    out_minutes_byte,
  output logic      [tcpg_pkg::HOURS_W-1:0]      out_hours_byte
);

  import tcpg_pkg::*;

  // register stages from input to output
  localparam int unsigned LAT = 13;

  // valid bits, one per stage
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  // stage 0: input capture, n+2 for the ten-minute term
  logic [31:0] n0_r;
  logic [30:0] np0_r;
  logic        pal0_r;
  logic [31:0] np2_full;

  // stages 1-2: count and mode ride along with the drop-frame dividers
  logic [31:0] n1_r, n2_r;
  logic        pal1_r, pal2_r;
  logic [30:0] a_q, b_q;
  logic [9:0]  a_r_unused;
  logic [13:0] b_r_unused;

  // stage 3: adjusted count
  logic [31:0] nadj_r;
  logic [31:0] nadj_nxt;
  logic        pal3_r;

  // rate divider out at stage 5
  logic [31:0] q1;
  logic [4:0]  fr5;
  // seconds divider out at stage 7
  logic [27:0] q2;
  logic [5:0]  sec7;
  logic [4:0]  fr6_r, fr7_r;
  // minutes divider out at stage 9
  logic [21:0] q3;
  logic [5:0]  min9;
  logic [4:0]  fr8_r, fr9_r;
  logic [5:0]  sec8_r, sec9_r;
  // hours divider out at stage 11
  logic [15:0] hq_unused;
  logic [4:0]  hr11;
  logic [4:0]  fr10_r, fr11_r;
  logic [5:0]  sec10_r, sec11_r;
  logic [5:0]  min10_r, min11_r;

  // output stage
  logic [FRAMES_W-1:0]  frames_r;
  logic [SECONDS_W-1:0] seconds_r;
  logic [MINUTES_W-1:0] minutes_r;
  logic [HOURS_W-1:0]   hours_r;

  assign busy = 1'b0;

  // valid pipeline
  assign vld_nxt = {vld_r[LAT-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign np2_full = in_frame_count + 32'd2;

  always_ff @(posedge clk) begin
    n0_r   <= in_frame_count;
    np0_r  <= np2_full[30:0];
    pal0_r <= in_is_fifty_hz;
    n1_r   <= n0_r;
    pal1_r <= pal0_r;
    n2_r   <= n1_r;
    pal2_r <= pal1_r;
  end

  // the doubled count wraps to 2*(n mod 2^31), so /1798 is (n mod 2^31)/899
  tcpg_cdiv #(
    .W  (31),
    .D0 (HALF_MIN_DROP),
    .D1 (HALF_MIN_DROP)
  ) u_div_min (
    .clk    (clk),
    .in_x   (n0_r[30:0]),
    .in_sel (1'b0),
    .out_q  (a_q),
    .out_r  (a_r_unused)
  );

  tcpg_cdiv #(
    .W  (31),
    .D0 (HALF_TEN_MIN_DROP),
    .D1 (HALF_TEN_MIN_DROP)
  ) u_div_ten_min (
    .clk    (clk),
    .in_x   (np0_r),
    .in_sel (1'b0),
    .out_q  (b_q),
    .out_r  (b_r_unused)
  );

  // drop-frame adjustment, wrapping
  assign nadj_nxt = pal2_r ? n2_r : (n2_r + {1'b0, a_q} - {1'b0, b_q});

  always_ff @(posedge clk) begin
    nadj_r <= nadj_nxt;
    pal3_r <= pal2_r;
  end

  // frames per second: 30 when sel low, 25 when high
  tcpg_cdiv #(
    .W  (32),
    .D0 (RATE_NTSC),
    .D1 (RATE_PAL)
  ) u_div_rate (
    .clk    (clk),
    .in_x   (nadj_r),
    .in_sel (pal3_r),
    .out_q  (q1),
    .out_r  (fr5)
  );

  // seconds count is below 2^28 at 25 fps and up
  tcpg_cdiv #(
    .W  (28),
    .D0 (SEC_PER_MIN),
    .D1 (SEC_PER_MIN)
  ) u_div_sec (
    .clk    (clk),
    .in_x   (q1[27:0]),
    .in_sel (1'b0),
    .out_q  (q2),
    .out_r  (sec7)
  );

  tcpg_cdiv #(
    .W  (22),
    .D0 (SEC_PER_MIN),
    .D1 (SEC_PER_MIN)
  ) u_div_min_of_hr (
    .clk    (clk),
    .in_x   (q2[21:0]),
    .in_sel (1'b0),
    .out_q  (q3),
    .out_r  (min9)
  );

  tcpg_cdiv #(
    .W  (16),
    .D0 (HOURS_PER_DAY),
    .D1 (HOURS_PER_DAY)
  ) u_div_hours (
    .clk    (clk),
    .in_x   (q3[15:0]),
    .in_sel (1'b0),
    .out_q  (hq_unused),
    .out_r  (hr11)
  );

  // remainders ride along until hours are known
  always_ff @(posedge clk) begin
    fr6_r   <= fr5;
    fr7_r   <= fr6_r;
    fr8_r   <= fr7_r;
    fr9_r   <= fr8_r;
    fr10_r  <= fr9_r;
    fr11_r  <= fr10_r;
    sec8_r  <= sec7;
    sec9_r  <= sec8_r;
    sec10_r <= sec9_r;
    sec11_r <= sec10_r;
    min10_r <= min9;
    min11_r <= min10_r;
  end

  // bcd conversion and drop flag
  always_ff @(posedge clk) begin
    frames_r  <= bcd2({1'b0, fr11_r}) | DROP_FLAG;
    seconds_r <= bcd2(sec11_r);
    minutes_r <= bcd2(min11_r);
    hours_r   <= HOURS_W'(bcd2({1'b0, hr11}));
  end

  assign out_valid        = vld_r[LAT-1];
  assign out_pack_id      = TC_PACK_ID;
  assign out_frames_byte  = frames_r;
  assign out_seconds_byte = seconds_r;
  assign out_minutes_byte = minutes_r;
  assign out_hours_byte   = hours_r;

  // every request gives one result after the fixed latency
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##13 out_valid)
    else $error("request without result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##13 !out_valid)
    else $error("result without request");

  // hours digits stay within 00 to 23
  a_hours_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hours_byte[3:0] <= 4'd9) &&
                  ((out_hours_byte[5:4] < 2'd2) || (out_hours_byte[3:0] < 4'd4)))
    else $error("hours out of range");

  // minutes and seconds digits stay within 00 to 59
  a_min_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_minutes_byte[6:4] < 3'd6) && (out_minutes_byte[3:0] <= 4'd9) &&
                  (out_seconds_byte[6:4] < 3'd6) && (out_seconds_byte[3:0] <= 4'd9))
    else $error("minutes or seconds out of range");

endmodule

`default_nettype wire

@@ src/tcpg_cdiv.sv @@
`timescale 1ns / 1ps
`default_nettype none

// two-stage divide by one of two constants: reciprocal multiply, then one correction
module tcpg_cdiv #(
  parameter int unsigned W  = 32,
  parameter int unsigned D0 = 30,
  parameter int unsigned D1 = 25,
  localparam int unsigned DMAX = (D0 > D1) ? D0 : D1,
  localparam int unsigned RW   = $clog2(DMAX)
) (
  input  wire logic          clk,
  input  wire logic [W-1:0]  in_x,
  input  wire logic          in_sel,
  output logic      [W-1:0]  out_q,
  output logic      [RW-1:0] out_r
);

  localparam longint unsigned M0 = (64'd1 << W) / D0;
  localparam longint unsigned M1 = (64'd1 << W) / D1;

  logic [W-1:0]   m_sel;
  logic [2*W-1:0] prod;
  logic [W-1:0]   x_r;
  logic [W-1:0]   q_est_r;
  logic           sel_r;

  logic [W-1:0]   d_sel;
  logic [W-1:0]   qd;
  logic [W-1:0]   diff;
  logic           corr;
  logic [W-1:0]   q_nxt;
  logic [W-1:0]   r_nxt;
  logic [W-1:0]   q_r;
  logic [RW-1:0]  r_r;

  // estimate is the quotient or one below it
  assign m_sel = in_sel ? W'(M1) : W'(M0);
  assign prod  = (2*W)'(in_x) * (2*W)'(m_sel);

  always_ff @(posedge clk) begin
    x_r     <= in_x;
    q_est_r <= prod[2*W-1:W];
    sel_r   <= in_sel;
  end

  assign d_sel = sel_r ? W'(D1) : W'(D0);
  assign qd    = q_est_r * d_sel;
  assign diff  = x_r - qd;
  assign corr  = (diff >= d_sel);
  assign q_nxt = corr ? q_est_r + W'(1) : q_est_r;
  assign r_nxt = corr ? diff - d_sel : diff;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt[RW-1:0];
  end

  assign out_q = q_r;
  assign out_r = r_r;

endmodule

`default_nettype wire

@@ test/tb_dv_timecode_pack_generator_unit.sv @@
`timescale 1ns / 1ps

module tb_dv_timecode_pack_generator_unit;
  import tcpg_pkg::*;

  // one request: frame count plus rate select
  typedef struct {
    bit [31:0] frame_count;
    bit        fifty_hz;
  } tc_request_t;

  // one timecode pack as it leaves the block
  typedef struct {
    bit [PACK_ID_W-1:0] pack_id;
    bit [FRAMES_W-1:0]  frames;
    bit [SECONDS_W-1:0] seconds;
    bit [MINUTES_W-1:0] minutes;
    bit [HOURS_W-1:0]   hours;
  } tc_pack_t;

  // pipeline depth is 13, so this tail is plenty to catch stray strobes
  localparam int unsigned DRAIN_CYCLES = 40;
  // cycles with neither a request nor a result taken before giving up
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 1200;
  // requests in this window are sent back to back with no gaps
  localparam int unsigned BURST_FIRST  = 400;
  localparam int unsigned BURST_LAST   = 700;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [COUNT_W-1:0]   in_frame_count = '0;
  logic                 in_is_fifty_hz = 1'b0;
  logic                 out_valid;
  logic [PACK_ID_W-1:0] out_pack_id;
  logic [FRAMES_W-1:0]  out_frames_byte;
  logic [SECONDS_W-1:0] out_seconds_byte;
  logic [MINUTES_W-1:0] out_minutes_byte;
  logic [HOURS_W-1:0]   out_hours_byte;

  tc_request_t request_q[$];   // requests not yet driven
  tc_pack_t    pack_q[$];      // packs owed by the block, oldest first
  int unsigned total_requests;
  int unsigned taken_cnt = 0;  // requests the block has taken
  int unsigned sent_cnt = 0;   // requests put on the bus
  int unsigned stall_cnt = 0;
  int unsigned err_cnt = 0;
  logic        req_taken = 1'b0;

  dv_timecode_pack_generator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_frame_count   (in_frame_count),
    .in_is_fifty_hz   (in_is_fifty_hz),
    .out_valid        (out_valid),
    .out_pack_id      (out_pack_id),
    .out_frames_byte  (out_frames_byte),
    .out_seconds_byte (out_seconds_byte),
    .out_minutes_byte (out_minutes_byte),
    .out_hours_byte   (out_hours_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // two bcd digits of v mod 100, tens in the upper nibble
  function automatic bit [7:0] bcd_of(input bit [31:0] v);
    bit [31:0] t;
    t = v % 32'd100;
    return {4'(t / 32'd10), 4'(t % 32'd10)};
  endfunction

  // expected pack for one request
  function automatic tc_pack_t timecode_pack_of(input tc_request_t req);
    tc_pack_t  p;
    bit [31:0] n;
    bit [31:0] rate;
    bit [31:0] per_min_drops;
    bit [31:0] per_ten_min_adds;
    n = req.frame_count;
    if (req.fifty_hz) begin
      rate = RATE_PAL;
    end else begin
      // drop-frame: doubled count and count plus two both wrap before dividing
      per_min_drops    = (n << 1) / 32'd1798;
      per_ten_min_adds = ((n + 32'd2) << 1) / 32'd17982;
      n = n + per_min_drops - per_ten_min_adds;
      rate = RATE_NTSC;
    end
    p.pack_id = TC_PACK_ID;
    // flag bit is set at both rates
    p.frames  = 7'(bcd_of(n % rate)) | DROP_FLAG;
    p.seconds = 7'(bcd_of((n / rate) % 32'd60));
    p.minutes = 7'(bcd_of((n / (32'd60 * rate)) % 32'd60));
    p.hours   = 6'(bcd_of((n / (32'd3600 * rate)) % 32'd24));
    return p;
  endfunction

  // append one request to the pending list
  function automatic void add_request(input bit [31:0] count, input bit fifty);
    tc_request_t r;
    r.frame_count = count;
    r.fifty_hz    = fifty;
    request_q.insert(request_q.size(), r);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // driver: changes inputs on the falling edge; a request stays up until taken
  always @(negedge clk) begin
    tc_request_t req;
    bit          pause;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      // about a quarter of slots stay empty, except inside the burst window
      pause = ($urandom_range(99) < 25) && !(sent_cnt >= BURST_FIRST && sent_cnt < BURST_LAST);
      if (request_q.size() != 0 && !pause) begin
        req = request_q.pop_front();
        in_frame_count <= req.frame_count;
        in_is_fifty_hz <= req.fifty_hz;
        start <= 1'b1;
        sent_cnt++;
      end else begin
        start <= 1'b0;
        // scramble the idle bus so the block is seen ignoring it
        in_frame_count <= $urandom;
        in_is_fifty_hz <= 1'($urandom);
      end
    end
  end

  // monitor: samples on the rising edge, checks results before logging the new request
  always @(posedge clk) begin
    tc_request_t req;
    tc_pack_t    want;
    if (rst_n) begin
      if (out_valid) begin
        if (pack_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual frames %h", $time,
                   out_frames_byte);
          err_cnt++;
        end else begin
          want = pack_q.pop_front();
          check_field("pack_id", want.pack_id, out_pack_id);
          check_field("frames_byte", want.frames, out_frames_byte);
          check_field("seconds_byte", want.seconds, out_seconds_byte);
          check_field("minutes_byte", want.minutes, out_minutes_byte);
          check_field("hours_byte", want.hours, out_hours_byte);
        end
      end
      if (start && !busy) begin
        req.frame_count = in_frame_count;
        req.fifty_hz    = in_is_fifty_hz;
        pack_q.insert(pack_q.size(), timecode_pack_of(req));
        taken_cnt <= taken_cnt + 1;
      end
      req_taken <= start && !busy;
      // watchdog on lack of progress
      if ((start && !busy) || out_valid) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= STALL_LIMIT) begin
        $display("dv_timecode_pack_generator_unit test failed");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end else begin
      req_taken <= 1'b0;
    end
  end

  // stimulus and end of run
  initial begin
    tc_request_t req;
    bit [31:0]   base;
    int unsigned kind;

    // directed part: corners of the count, wrap points and rollover edges
    add_request(32'd0, 1'b0);
    add_request(32'd0, 1'b1);
    add_request(32'hFFFF_FFFF, 1'b0);
    add_request(32'hFFFF_FFFF, 1'b1);
    // doubled count at its last value before wrapping, then wrapping
    add_request(32'h7FFF_FFFF, 1'b0);
    add_request(32'h8000_0000, 1'b0);
    // count plus two just before its wrap, then wrapping
    add_request(32'hFFFF_FFFD, 1'b0);
    add_request(32'hFFFF_FFFE, 1'b0);
    // per-minute drop term stepping at 899 and at the one-minute mark
    add_request(32'd1798, 1'b0);
    add_request(32'd1799, 1'b0);
    add_request(32'd898, 1'b0);
    add_request(32'd899, 1'b0);
    // ten-minute mark, where nothing is dropped
    add_request(32'd17981, 1'b0);
    add_request(32'd17982, 1'b0);
    // hours rolling over from 23 to 00 at each rate
    add_request(32'd2159999, 1'b1);
    add_request(32'd2160000, 1'b1);
    add_request(32'd2589407, 1'b0);
    add_request(32'd2589408, 1'b0);
    // alternating bit patterns on the count
    add_request(32'h5555_5555, 1'b0);
    add_request(32'hAAAA_AAAA, 1'b1);
    add_request(32'h5555_5555, 1'b1);
    add_request(32'hAAAA_AAAA, 1'b0);

    // random part: full range, within a day, near drop points, near wrap
    repeat (RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        req.frame_count = $urandom;
      end else if (kind < 70) begin
        req.frame_count = $urandom_range(2700000);
      end else if (kind < 90) begin
        base = ($urandom_range(1) != 0) ? 32'd899 * $urandom_range(4000)
                                        : 32'd8991 * $urandom_range(400);
        req.frame_count = base + $urandom_range(4) - 32'd2;
      end else begin
        base = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h0;
        req.frame_count = base - 32'd20 + $urandom_range(40);
      end
      req.fifty_hz = 1'($urandom);
      add_request(req.frame_count, req.fifty_hz);
    end
    total_requests = request_q.size();

    // synchronous reset, released on a falling edge
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // wait until every request is taken and every pack has come back
    @(negedge clk);
    while (taken_cnt != total_requests || pack_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_cnt == 0 && pack_q.size() == 0) begin
      $display("dv_timecode_pack_generator_unit test passed");
    end else begin
      $display("dv_timecode_pack_generator_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/tcpg_pkg.sv
src/tcpg_cdiv.sv
src/dv_timecode_pack_generator_unit.sv
test/tb_dv_timecode_pack_generator_unit.sv
